[rtl/text_console_writer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the text console writer
// Shared property shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Geometry, character codes, request/result types and helpers of the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS    = 80;
  localparam int ROWS    = 25;
  localparam int NCELLS  = ROWS * COLS;
  localparam int CELL_AW = $clog2(NCELLS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int COL_W   = $clog2(COLS);

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] RESET_ATTR = 8'd7;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic REG_CHAR_COLOR = 1'b0;
  localparam logic REG_FILL_COLOR = 1'b1;

  typedef struct packed {
    logic        op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } out_res_t;

  typedef struct packed {
    logic [7:0] char_color;
    logic [7:0] fill_color;
  } cfg_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [15:0]        wdata;
    logic               re;
    logic [CELL_AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } ctrl_state_t;

  function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] attr);
    return {attr, ch};
  endfunction

  function automatic logic [4:0] row_field(input logic [ROW_W-1:0] row);
    logic [31:0] wide;
    wide = 32'(row);
    return wide[4:0];
  endfunction

  function automatic logic [6:0] col_field(input logic [COL_W-1:0] col);
    logic [31:0] wide;
    wide = 32'(col);
    return wide[6:0];
  endfunction

endpackage

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: cursor, character writes, scrolling and cell reads.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// in_data.op selects a put (print char_code at the cursor, or newline and
// carriage return) or a read of the cell at in_data.cell_index.
// Every request gives one result on out_data, shown for exactly one cycle
// with out_valid high. The receiver cannot stall, so results never wait.
// A put that does not scroll finishes in its accept cycle: its result shows
// in the next cycle and busy stays low, so puts run at one per cycle.
// A read issues one access to the cell memory; its data returns in the next
// cycle, in the read state, where the result register takes it; busy is high
// in the read state, so a new request waits until the read is through.
// A put that moves the cursor past the bottom row scrolls: the copy walks
// the cell memory one cell per cycle, then blanks the bottom row in
// fill_color, holding busy high until the bottom row is blank.
// After reset the block sweeps the cell memory, writing spaces in the reset
// fill color one cell per cycle; busy is high until the sweep is done.
// The color registers on the APB port can be written at any idle time;
// pready is always high.
// ----------------------------------------------------------------------------
module text_console_writer
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_data,
  // Result channel
  output logic        out_valid,
  output out_res_t    out_data,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  mem_req_t    mem_req;
  logic [15:0] mem_rdata;

  // Color registers.
  tcw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: owns the cursor and drives every access to the cell memory.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Screen cells, one 16-bit word per character position.
  tcw_cell_ram u_cells (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

[rtl/tcw_regs.sv]
// ----------------------------------------------------------------------------
// tcw_regs
// Configuration registers: character color and fill color, APB-style access.
// ----------------------------------------------------------------------------
module tcw_regs
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [7:0] char_color_r, char_color_nxt;
  logic [7:0] fill_color_r, fill_color_nxt;
  logic       wr_en;

  // Registers sit on word addresses; bit 2 selects one of the two.
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    char_color_nxt = char_color_r;
    fill_color_nxt = fill_color_r;
    if (wr_en) begin
      case (paddr[2])
        REG_CHAR_COLOR: char_color_nxt = pwdata[7:0];
        REG_FILL_COLOR: fill_color_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_color_r <= RESET_ATTR;
      fill_color_r <= RESET_ATTR;
    end else begin
      char_color_r <= char_color_nxt;
      fill_color_r <= fill_color_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_CHAR_COLOR: prdata = {24'd0, char_color_r};
      REG_FILL_COLOR: prdata = {24'd0, fill_color_r};
      default:        prdata = 32'd0;
    endcase
  end

  assign pready         = 1'b1;
  assign cfg.char_color = char_color_r;
  assign cfg.fill_color = fill_color_r;

endmodule

[rtl/tcw_cell_ram.sv]
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_cell_ram
  import tcw_pkg::*;
(
  input  logic        clk,
  input  mem_req_t    req,
  output logic [15:0] rdata
);

  logic [15:0] cells [NCELLS];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= cells[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Cursor, request sequencing, scroll copy and clear sweeps over the cell store.
// ----------------------------------------------------------------------------
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_req_t     in_data,
  output logic        busy,
  input  cfg_t        cfg,
  output mem_req_t    mem_req,
  input  logic [15:0] mem_rdata,
  output logic        out_valid,
  output out_res_t    out_data
);

  `include "text_console_writer_assert.svh"

  localparam logic [CELL_AW-1:0] LAST_CELL   = CELL_AW'(NCELLS - 1);
  localparam logic [CELL_AW-1:0] LAST_COPY   = CELL_AW'(NCELLS - COLS - 1);
  localparam logic [CELL_AW-1:0] ROW_STRIDE  = CELL_AW'(COLS);
  localparam logic [ROW_W-1:0]   BOTTOM_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]   LAST_COLUMN = COL_W'(COLS - 1);

  ctrl_state_t        state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  logic               cp_pend_r, cp_pend_nxt;
  logic [CELL_AW-1:0] cp_addr_r, cp_addr_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_res_t           out_r, out_nxt;

  logic               accept;
  logic               is_newline, is_return, printable, row_step, needs_scroll;
  logic [ROW_W-1:0]   put_row;
  logic [COL_W-1:0]   put_col;
  logic [31:0]        pos_wide, idx_wide;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Cursor update of a put request, worked out from the current cursor.
  assign is_newline   = (in_data.char_code == CH_NEWLINE);
  assign is_return    = (in_data.char_code == CH_RETURN);
  assign printable    = !is_newline && !is_return;
  assign row_step     = is_newline || (printable && (col_r == LAST_COLUMN));
  assign needs_scroll = row_step && (row_r == BOTTOM_ROW);
  assign pos_wide     = 32'(row_r) * 32'(COLS) + 32'(col_r);
  assign idx_wide     = 32'(in_data.cell_index);

  always_comb begin
    put_row = row_r;
    put_col = col_r;
    if (row_step) begin
      put_col = '0;
      put_row = needs_scroll ? BOTTOM_ROW : row_r + ROW_W'(1);
    end else if (is_return) begin
      put_col = '0;
    end else begin
      put_col = col_r + COL_W'(1);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST_CELL) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_READ) begin
            state_nxt = ST_READ;
          end else if (needs_scroll) begin
            state_nxt = ST_SCROLL;
          end
        end
      end
      ST_READ:   state_nxt = ST_IDLE;
      ST_SCROLL: begin
        if (cnt_r == LAST_COPY) state_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (!cp_pend_r && (cnt_r == LAST_CELL)) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    cp_pend_nxt   = 1'b0;
    cp_addr_nxt   = cp_addr_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_req       = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = cnt_r;
        mem_req.wdata = make_cell(CH_SPACE, RESET_ATTR);
        cnt_nxt       = (cnt_r == LAST_CELL) ? '0 : cnt_r + CELL_AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_READ) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_wide[CELL_AW-1:0];
            rd_ok_nxt     = (idx_wide < 32'(NCELLS));
          end else begin
            mem_req.we    = printable;
            mem_req.waddr = pos_wide[CELL_AW-1:0];
            mem_req.wdata = make_cell(in_data.char_code, cfg.char_color);
            row_nxt       = put_row;
            col_nxt       = put_col;
            if (needs_scroll) begin
              cnt_nxt = '0;
            end else begin
              out_valid_nxt         = 1'b1;
              out_nxt.cell_value    = 16'd0;
              out_nxt.cursor_row    = row_field(put_row);
              out_nxt.cursor_column = col_field(put_col);
              out_nxt.scrolled      = 1'b0;
            end
          end
        end
      end
      ST_READ: begin
        out_valid_nxt         = 1'b1;
        out_nxt.cell_value    = rd_ok_r ? mem_rdata : 16'd0;
        out_nxt.cursor_row    = row_field(row_r);
        out_nxt.cursor_column = col_field(col_r);
        out_nxt.scrolled      = 1'b0;
      end
      ST_SCROLL: begin
        // Read one row below the destination; the write follows in the next cycle.
        mem_req.re    = 1'b1;
        mem_req.raddr = cnt_r + ROW_STRIDE;
        cp_pend_nxt   = 1'b1;
        cp_addr_nxt   = cnt_r;
        cnt_nxt       = cnt_r + CELL_AW'(1);
        if (cp_pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cp_addr_r;
          mem_req.wdata = mem_rdata;
        end
      end
      ST_FILL: begin
        mem_req.we = 1'b1;
        if (cp_pend_r) begin
          // Last copied cell still owns the write port this cycle.
          mem_req.waddr = cp_addr_r;
          mem_req.wdata = mem_rdata;
        end else begin
          mem_req.waddr = cnt_r;
          mem_req.wdata = make_cell(CH_SPACE, cfg.fill_color);
          if (cnt_r == LAST_CELL) begin
            cnt_nxt               = '0;
            out_valid_nxt         = 1'b1;
            out_nxt.cell_value    = 16'd0;
            out_nxt.cursor_row    = row_field(row_r);
            out_nxt.cursor_column = col_field(col_r);
            out_nxt.scrolled      = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CELL_AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      cp_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      cp_pend_r   <= cp_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cp_addr_nxt;
    rd_ok_r   <= rd_ok_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TCW_ASSERT_SAME(a_scroll_on_bottom, out_valid_r && out_r.scrolled,
    out_r.cursor_row == row_field(BOTTOM_ROW), "scroll result not on bottom row")
  `TCW_ASSERT_NEXT(a_read_result, state_r == ST_READ,
    out_valid_r && !out_r.scrolled, "read request gave no result")
  `TCW_ASSERT_NEXT(a_put_result,
    accept && (in_data.op == OP_PUT) && !needs_scroll,
    out_valid_r && !out_r.scrolled && (out_r.cell_value == 16'd0),
    "put request without scroll gave no result")
  `TCW_ASSERT_SAME(a_no_port_collision, mem_req.we && mem_req.re,
    mem_req.waddr != mem_req.raddr, "read and write hit the same cell")
  `TCW_ASSERT_SAME(a_copy_pairs, cp_pend_r,
    (state_r == ST_SCROLL) || (state_r == ST_FILL), "copy write outside scroll")

endmodule
